// ===== hdl/tmd_pkg.sv =====
// Package for the typed message deframer: sizes, register indexes and beat types.
// Used by the stream interfaces and by the top level.
package tmd_pkg;

  localparam int unsigned MAX_PAYLOAD = 64;
  localparam int unsigned ADDR_W      = $clog2(MAX_PAYLOAD);
  localparam int unsigned CNT_W       = $clog2(MAX_PAYLOAD + 1);

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 64;

  localparam logic [CFG_IDX_W-1:0] CFG_CONSOLE_CODE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TYPE_COUNT   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LENGTH_TABLE = 2'd2;

  localparam logic [7:0] CHAR_CR = 8'h0D;
  localparam logic [7:0] CHAR_LF = 8'h0A;
  localparam logic [3:0] MAX_TYPE_COUNT = 4'd8;

  typedef struct packed {
    logic [7:0] rx_byte;
  } rx_beat_t;

  typedef struct packed {
    logic [7:0] msg_type;
    logic [7:0] data_byte;
    logic [5:0] byte_index;
    logic       last;
  } msg_beat_t;

endpackage

// ===== hdl/tmd_stream_if.sv =====
// Valid/ready stream interfaces for received bytes and delivered message beats.
// Depends on tmd_pkg for the beat types.
interface tmd_rx_if;
  import tmd_pkg::*;
  logic     valid;
  logic     ready;
  rx_beat_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface tmd_msg_if;
  import tmd_pkg::*;
  logic      valid;
  logic      ready;
  msg_beat_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// ===== hdl/typed_message_deframer_top.sv =====
// Typed message deframer: rebuilds typed messages from received bytes and reads them
// out of a payload store. Depends on tmd_pkg and the interfaces in tmd_stream_if.sv.
// Received bytes are taken one per cycle while a message is being collected.
// The first beat of a completed message is issued in the emit state and read out
// through the store's registered read port; readout gives one beat per cycle while
// the output is not stalled, and input is held off until the last beat is issued.
// Reset clears control state and configuration, not the payload store or output beat.
module typed_message_deframer_top (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [tmd_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [tmd_pkg::CFG_DATA_W-1:0] cfg_data_i,
  tmd_rx_if.sink                         rx_i,
  tmd_msg_if.source                      msg_o
);
  import tmd_pkg::*;

  localparam logic [1:0] ST_HEADER = 2'd0;
  localparam logic [1:0] ST_BODY   = 2'd1;
  localparam logic [1:0] ST_EMIT   = 2'd2;

  logic [7:0]  console_code_q;
  logic [3:0]  type_count_q;
  logic [63:0] length_table_q;

  logic [1:0]       state_q, state_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic [7:0]       cur_type_q, cur_type_d;
  logic [7:0]       exp_len_q, exp_len_d;
  logic [CNT_W-1:0] rd_cnt_q, rd_cnt_d;
  logic [CNT_W-1:0] emit_len_q, emit_len_d;
  logic             out_valid_q;

  logic [7:0] mem_q [MAX_PAYLOAD];
  logic [7:0] rdata_q;
  logic [7:0] out_type_q;
  logic [5:0] out_idx_q;
  logic       out_last_q;

  logic       rx_fire;
  logic [7:0] ch;
  logic [3:0] tc;
  logic       wr_en;
  logic       full;
  logic       deliver;
  logic       is_term;
  logic       issue;
  logic       issue_last;

  assign ch      = rx_i.payload.rx_byte;
  assign rx_fire = rx_i.valid && rx_i.ready;
  assign rx_i.ready = (state_q != ST_EMIT);

  assign tc      = (type_count_q > MAX_TYPE_COUNT) ? MAX_TYPE_COUNT : type_count_q;
  assign full    = (count_q == CNT_W'(MAX_PAYLOAD));
  assign is_term = (ch == CHAR_CR) || (ch == CHAR_LF);
  assign wr_en   = rx_fire && (state_q == ST_BODY) && !full;

  assign issue      = (state_q == ST_EMIT) && (!out_valid_q || msg_o.ready);
  assign issue_last = (rd_cnt_q + 1'b1) == emit_len_q;

  // Table types deliver on the count after this byte's store; console on CR or LF.
  always_comb begin
    logic [CNT_W-1:0] cnt_after;
    cnt_after = full ? count_q : count_q + 1'b1;
    if (cur_type_q == console_code_q) begin
      deliver = is_term;
    end else begin
      deliver = !full && ({1'b0, exp_len_q} == 9'(cnt_after));
    end
  end

  always_comb begin
    state_d    = state_q;
    count_d    = count_q;
    cur_type_d = cur_type_q;
    exp_len_d  = exp_len_q;
    rd_cnt_d   = rd_cnt_q;
    emit_len_d = emit_len_q;
    case (state_q)
      ST_HEADER: begin
        if (rx_fire) begin
          if (ch == console_code_q) begin
            state_d    = ST_BODY;
            cur_type_d = ch;
            exp_len_d  = 8'd0;
            count_d    = '0;
          end else if ((ch != 8'd0) && (ch < {4'd0, tc})) begin
            state_d    = ST_BODY;
            cur_type_d = ch;
            exp_len_d  = length_table_q[{ch[2:0], 3'b000} +: 8];
            count_d    = '0;
          end
        end
      end
      ST_BODY: begin
        if (rx_fire) begin
          if (deliver) begin
            state_d    = ST_EMIT;
            emit_len_d = full ? count_q : count_q + 1'b1;
            rd_cnt_d   = '0;
            count_d    = '0;
          end else if (full) begin
            // A byte at a full buffer discards a message that did not complete.
            state_d = ST_HEADER;
            count_d = '0;
          end else begin
            count_d = count_q + 1'b1;
          end
        end
      end
      ST_EMIT: begin
        if (issue) begin
          rd_cnt_d = rd_cnt_q + 1'b1;
          if (issue_last) begin
            state_d = ST_HEADER;
          end
        end
      end
      default: begin
        state_d = ST_HEADER;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      console_code_q <= 8'd0;
      type_count_q   <= 4'd1;
      length_table_q <= 64'd0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_CONSOLE_CODE: console_code_q <= cfg_data_i[7:0];
        CFG_TYPE_COUNT:   type_count_q   <= cfg_data_i[3:0];
        CFG_LENGTH_TABLE: length_table_q <= cfg_data_i[63:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_HEADER;
      count_q     <= '0;
      cur_type_q  <= 8'd0;
      exp_len_q   <= 8'd0;
      rd_cnt_q    <= '0;
      emit_len_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      count_q    <= count_d;
      cur_type_q <= cur_type_d;
      exp_len_q  <= exp_len_d;
      rd_cnt_q   <= rd_cnt_d;
      emit_len_q <= emit_len_d;
      if (issue) begin
        out_valid_q <= 1'b1;
      end else if (msg_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // The store's read register doubles as the output beat register. The type is held
  // with it, as a new header may be taken while the last beat still waits.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[count_q[ADDR_W-1:0]] <= ch;
    end
    if (issue) begin
      rdata_q    <= mem_q[rd_cnt_q[ADDR_W-1:0]];
      out_type_q <= cur_type_q;
      out_idx_q  <= 6'(rd_cnt_q);
      out_last_q <= issue_last;
    end
  end

  assign msg_o.valid              = out_valid_q;
  assign msg_o.payload.msg_type   = out_type_q;
  assign msg_o.payload.data_byte  = rdata_q;
  assign msg_o.payload.byte_index = out_idx_q;
  assign msg_o.payload.last       = out_last_q;

endmodule
